// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the noise gate unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every posedge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/core/ngh_pkg.sv =====
package ngh_pkg;

   // operand and accumulator widths of the shared multiplier
   localparam int OPND_W  = 24;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int COEFF_W = 16;
   localparam int LEVEL_W = 24;

   // fixed-point constants
   localparam logic [LEVEL_W-1:0]   ONE_Q23   = 24'd8388608;
   localparam logic [LEVEL_W-1:0]   HALF_Q23  = 24'd4194304;
   localparam logic [LEVEL_W-1:0]   POS_MAX   = 24'h7FFFFF;
   localparam logic [LEVEL_W-1:0]   NEG_MIN   = 24'h800000;
   localparam logic [COEFF_W:0]     COEFF_ONE = 17'h10000;

   // configuration register indexes
   localparam logic [2:0] REG_DET_ATTACK   = 3'd0;
   localparam logic [2:0] REG_DET_RELEASE  = 3'd1;
   localparam logic [2:0] REG_GAIN_ATTACK  = 3'd2;
   localparam logic [2:0] REG_GAIN_RELEASE = 3'd3;
   localparam logic [2:0] REG_HOLD_SAMPLES = 3'd4;
   localparam logic [2:0] REG_OPEN_THRESH  = 3'd5;
   localparam logic [2:0] REG_CLOSE_THRESH = 3'd6;
   localparam logic [2:0] REG_FLOOR_GAIN   = 3'd7;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DET_A,
      ST_DET_B,
      ST_DET_C,
      ST_GATE,
      ST_GAIN_A,
      ST_GAIN_B,
      ST_GAIN_C,
      ST_SCALE_L,
      ST_SCALE_R,
      ST_FIN
   } state_type;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctrl_type;

   // sample times gain over 2^23, rounded down, saturated to 24-bit signed
   function automatic logic [LEVEL_W-1:0] scale_result(input logic neg,
                                                       input logic [PROD_W-1:0] prod);
      logic [PROD_W:0]  rsum;
      logic [PROD_W-23:0] q;
      logic [LEVEL_W-1:0] res;
      rsum = {1'b0, prod} + (PROD_W+1)'(24'h7FFFFF);
      if (!neg) begin
         q = {1'b0, prod[PROD_W-1:23]};
         res = (q > (PROD_W-22)'(POS_MAX)) ? POS_MAX : q[LEVEL_W-1:0];
      end else begin
         q = rsum[PROD_W:23];
         res = (q >= (PROD_W-22)'(NEG_MIN)) ? NEG_MIN : (~q[LEVEL_W-1:0] + 24'd1);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/noise_gate_hysteresis_hold_unit.sv =====
// a request beat walks DET_A, DET_B, DET_C, GATE, GAIN_A, GAIN_B, GAIN_C,
//   SCALE_L, SCALE_R and FIN before rsp_tvalid; frames enter only in IDLE;
//   one shared 24x24 multiplier does four smoother, two gain products in turn
// reset: synchronous, active high; clears envelope, gain, hold and gate state
//   and loads the register defaults; no clearing pass
`include "assert_macros.svh"
module noise_gate_hysteresis_hold_unit #(
   parameter int CHANNELS  = 2,
   parameter int HOLD_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   // request: [23:0] sample_left, [47:24] sample_right
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: [23:0] gated_left, [47:24] gated_right
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // response: [0] gate_is_open, [1] gain_above_half
   output logic [1:0]  rsp_tuser,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);
   import ngh_pkg::*;

   state_type state_ff, state_in;

   // configuration registers
   logic [COEFF_W-1:0] det_att_ff, det_rel_ff, gain_att_ff, gain_rel_ff;
   logic [19:0]        hold_len_ff;
   logic [LEVEL_W-1:0] open_thr_ff, close_thr_ff, floor_ff;

   // frame payload
   logic               neg_l_ff, neg_r_ff, neg_l_in, neg_r_in;
   logic [LEVEL_W-1:0] mag_l_ff, mag_r_ff, mag_l_in, mag_r_in;
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [COEFF_W-1:0] det_coeff_ff, det_coeff_in;
   logic [COEFF_W-1:0] gain_coeff_ff, gain_coeff_in;
   logic [LEVEL_W-1:0] target_ff, target_in;
   logic [LEVEL_W-1:0] res_l_ff, res_l_in;

   // gate state
   logic [LEVEL_W-1:0]   env_ff, env_in;
   logic [LEVEL_W-1:0]   gain_ff, gain_in;
   logic [HOLD_BITS-1:0] hold_ff, hold_in, hold_load;
   logic                 gate_ff, gate_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic               rsp_open_ff, rsp_open_in, rsp_half_ff, rsp_half_in;

   // shared unit
   mac_ctrl_type      mac_ctrl;
   logic [OPND_W-1:0] op_a, op_b;
   logic [PROD_W-1:0] prod, acc;
   logic [LEVEL_W-1:0] acc_level;
   logic               accept, out_free;

   ngh_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   assign acc_level = acc[LEVEL_W+15:16];
   assign hold_load = HOLD_BITS'(hold_len_ff);
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         det_att_ff   <= 16'd65000;
         det_rel_ff   <= 16'd65500;
         gain_att_ff  <= 16'd65000;
         gain_rel_ff  <= 16'd65500;
         hold_len_ff  <= 20'd4800;
         open_thr_ff  <= 24'd83886;
         close_thr_ff <= 24'd41943;
         floor_ff     <= 24'd0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_DET_ATTACK:   det_att_ff   <= csr_wdata[COEFF_W-1:0];
            REG_DET_RELEASE:  det_rel_ff   <= csr_wdata[COEFF_W-1:0];
            REG_GAIN_ATTACK:  gain_att_ff  <= csr_wdata[COEFF_W-1:0];
            REG_GAIN_RELEASE: gain_rel_ff  <= csr_wdata[COEFF_W-1:0];
            REG_HOLD_SAMPLES: hold_len_ff  <= csr_wdata[19:0];
            REG_OPEN_THRESH:  open_thr_ff  <= csr_wdata;
            REG_CLOSE_THRESH: close_thr_ff <= csr_wdata;
            REG_FLOOR_GAIN:   floor_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_DET_A;
         ST_DET_A:   state_in = ST_DET_B;
         ST_DET_B:   state_in = ST_DET_C;
         ST_DET_C:   state_in = ST_GATE;
         ST_GATE:    state_in = ST_GAIN_A;
         ST_GAIN_A:  state_in = ST_GAIN_B;
         ST_GAIN_B:  state_in = ST_GAIN_C;
         ST_GAIN_C:  state_in = ST_SCALE_L;
         ST_SCALE_L: state_in = ST_SCALE_R;
         ST_SCALE_R: state_in = ST_FIN;
         ST_FIN:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mac_ctrl   = '0;
      op_a       = '0;
      op_b       = '0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DET_A: begin
            mac_ctrl.mul_en = 1'b1;
            op_a = env_ff;
            op_b = OPND_W'(det_coeff_ff);
         end
         ST_DET_B: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
            op_a = peak_ff;
            op_b = OPND_W'(COEFF_ONE - (COEFF_W+1)'(det_coeff_ff));
         end
         ST_DET_C: mac_ctrl.acc_add = 1'b1;
         ST_GAIN_A: begin
            mac_ctrl.mul_en = 1'b1;
            op_a = gain_ff;
            op_b = OPND_W'(gain_coeff_ff);
         end
         ST_GAIN_B: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
            op_a = target_ff;
            op_b = OPND_W'(COEFF_ONE - (COEFF_W+1)'(gain_coeff_ff));
         end
         ST_GAIN_C: mac_ctrl.acc_add = 1'b1;
         ST_SCALE_L: begin
            mac_ctrl.mul_en = 1'b1;
            op_a = mag_l_ff;
            op_b = acc_level;
         end
         ST_SCALE_R: begin
            mac_ctrl.mul_en = 1'b1;
            op_a = mag_r_ff;
            op_b = gain_ff;
         end
         default: ;
      endcase
   end

   // frame capture: magnitudes, peak and detector coefficient
   always_comb begin
      neg_l_in     = neg_l_ff;
      neg_r_in     = neg_r_ff;
      mag_l_in     = mag_l_ff;
      mag_r_in     = mag_r_ff;
      peak_in      = peak_ff;
      det_coeff_in = det_coeff_ff;
      if (accept) begin
         neg_l_in = req_tdata[23];
         neg_r_in = req_tdata[47];
         mag_l_in = req_tdata[23] ? (~req_tdata[23:0] + 24'd1) : req_tdata[23:0];
         mag_r_in = req_tdata[47] ? (~req_tdata[47:24] + 24'd1) : req_tdata[47:24];
         peak_in  = mag_l_in;
         if (CHANNELS >= 2 && mag_r_in > mag_l_in) begin
            peak_in = mag_r_in;
         end
         det_coeff_in = (peak_in > env_ff) ? det_att_ff : det_rel_ff;
      end
   end

   // gate decision on the new envelope
   always_comb begin
      env_in        = env_ff;
      hold_in       = hold_ff;
      gate_in       = gate_ff;
      target_in     = target_ff;
      gain_coeff_in = gain_coeff_ff;
      if (state_ff == ST_GATE) begin
         env_in = acc_level;
         if (acc_level >= open_thr_ff) begin
            gate_in = 1'b1;
            hold_in = hold_load;
         end else if (gate_ff) begin
            if (acc_level >= close_thr_ff) begin
               hold_in = hold_load;
            end else if (hold_ff != '0) begin
               hold_in = hold_ff - HOLD_BITS'(1);
            end else begin
               gate_in = 1'b0;
            end
         end
         target_in     = gate_in ? ONE_Q23 : floor_ff;
         gain_coeff_in = gate_in ? gain_att_ff : gain_rel_ff;
      end
   end

   // gain update and scaled results
   always_comb begin
      gain_in      = gain_ff;
      res_l_in     = res_l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_open_in  = rsp_open_ff;
      rsp_half_in  = rsp_half_ff;
      if (state_ff == ST_SCALE_L) begin
         gain_in = acc_level;
      end
      if (state_ff == ST_SCALE_R) begin
         res_l_in = scale_result(neg_l_ff, prod);
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = res_l_ff;
         rsp_right_in = (CHANNELS >= 2) ? scale_result(neg_r_ff, prod) : '0;
         rsp_open_in  = gate_ff;
         rsp_half_in  = gain_ff > HALF_Q23;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         gain_ff      <= '0;
         hold_ff      <= '0;
         gate_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_l_ff      <= neg_l_in;
      neg_r_ff      <= neg_r_in;
      mag_l_ff      <= mag_l_in;
      mag_r_ff      <= mag_r_in;
      peak_ff       <= peak_in;
      det_coeff_ff  <= det_coeff_in;
      gain_coeff_ff <= gain_coeff_in;
      target_ff     <= target_in;
      res_l_ff      <= res_l_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_half_ff   <= rsp_half_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};
   assign rsp_tuser  = {rsp_half_ff, rsp_open_ff};

   // hold counter moves only on the gate decision step
   `ASSERT_HOLDS(a_hold_only_in_gate, clock, reset, (!reset && state_ff != ST_GATE) |=> $stable(hold_ff), "hold counter changed outside gate step")
   // gate closes only once the hold has run out
   `ASSERT_HOLDS(a_close_after_hold, clock, reset, ($fell(gate_ff) && !$past(reset)) |-> ($past(hold_ff) == '0), "gate closed with hold pending")
   // envelope at the open threshold opens the gate and reloads the hold
   `ASSERT_HOLDS(a_open_reload, clock, reset, (!reset && state_ff == ST_GATE && acc_level >= open_thr_ff) |=> (gate_ff && hold_ff == hold_load), "open threshold did not open gate")
   // a finished frame waits while the output register is still full
   `ASSERT_HOLDS(a_fin_waits, clock, reset, (!reset && state_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FIN), "result dropped while output stalled")

endmodule

// ===== rtl/core/ngh_mac.sv =====
module ngh_mac (
   input  logic                         clock,
   input  ngh_pkg::mac_ctrl_type        ctrl,
   input  logic [ngh_pkg::OPND_W-1:0]   op_a,
   input  logic [ngh_pkg::OPND_W-1:0]   op_b,
   output logic [ngh_pkg::PROD_W-1:0]   prod,
   output logic [ngh_pkg::PROD_W-1:0]   acc
);
   import ngh_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] acc_ff, acc_in;

   // product register, holds when the multiplier is idle
   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul_en) begin
         prod_in = op_a * op_b;
      end
   end

   // accumulator takes the previous product or adds it
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = prod_ff;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

// ===== tb/noise_gate_hysteresis_hold_unit_tb.sv =====
`timescale 1ns / 1ps

module noise_gate_hysteresis_hold_unit_tb;
   import ngh_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASE_FRAMES    = 160;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 300;

   // one result beat as the block should produce it
   typedef struct packed {
      logic [23:0] gated_left;
      logic [23:0] gated_right;
      logic        gate_open;
      logic        gain_high;
   } gated_frame_type;

   // directed stimulus row: frame plus an optional hand-written result
   typedef struct packed {
      logic            has_fixed;
      gated_frame_type fixed_result;
      logic [23:0]     right;
      logic [23:0]     left;
   } directed_row_type;

   localparam gated_frame_type GATED_ZERO = '0;

   // defaults: silence, then full scale both polarities; the gate stays shut
   // and the gain is still zero for these two, so every output is zero
   localparam directed_row_type DIRECTED_ROWS [0:21] = '{
      {1'b1, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b1, GATED_ZERO, 24'h800000, 24'h7FFFFF},
      {1'b0, GATED_ZERO, 24'h7FFFFF, 24'h800000},
      {1'b0, GATED_ZERO, 24'h800000, 24'h800000},
      {1'b0, GATED_ZERO, 24'h7FFFFF, 24'h7FFFFF},
      {1'b0, GATED_ZERO, 24'hFFFFFF, 24'h000001},
      {1'b0, GATED_ZERO, 24'h000001, 24'hFFFFFF},
      {1'b0, GATED_ZERO, 24'hC00000, 24'h400000},
      {1'b0, GATED_ZERO, 24'hAAAAAA, 24'h555555},
      {1'b0, GATED_ZERO, 24'h555555, 24'hAAAAAA},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000000},
      {1'b0, GATED_ZERO, 24'h000000, 24'h000001},
      {1'b0, GATED_ZERO, 24'h000000, 24'h800000},
      {1'b0, GATED_ZERO, 24'h800000, 24'h000000},
      {1'b0, GATED_ZERO, 24'hEDCBA9, 24'h123456}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [23:0] csr_wdata  = '0;

   // register copies
   logic [15:0] det_attack_c, det_release_c, gain_attack_c, gain_release_c;
   logic [19:0] hold_len;
   logic [23:0] open_lvl, close_lvl, floor_lvl;

   // gate state copies
   logic [23:0] env_lvl, gain_lvl;
   logic [19:0] hold_left;
   logic        gate_open;

   gated_frame_type gated_expect_q [$];
   int              fail_count    = 0;
   int              cycle_count   = 0;
   logic            gaps_on       = 1'b1;
   int              hold_off_req  = 0;
   int              hold_off_seen = 0;
   int              stall_left    = 0;
   int              rsp_draw;

   noise_gate_hysteresis_hold_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // one-pole step: floor((c * old + (1 - c) * x)), c in Q0.16
   function automatic logic [23:0] one_pole(input logic [15:0] c, input logic [23:0] old,
                                            input logic [23:0] x);
      logic [63:0] acc;
      acc = 64'(c) * 64'(old) + (64'd65536 - 64'(c)) * 64'(x);
      return acc[39:16];
   endfunction

   // sample times gain over 2^23, rounded down, saturated
   function automatic logic [23:0] scale_by_gain(input logic signed [23:0] s,
                                                 input logic [23:0] g);
      longint sv, gv, q;
      sv = s;
      gv = g;
      if (sv >= 0) q = (sv * gv) >>> 23;
      else q = -(((-sv) * gv + 64'sd8388607) >>> 23);
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[23:0];
   endfunction

   // unsigned magnitude; full-scale negative gives 1.0
   function automatic logic [23:0] magnitude(input logic [23:0] s);
      return s[23] ? (~s + 24'd1) : s;
   endfunction

   // advance the gate state by one frame and return its output beat
   function automatic gated_frame_type compute_gated_frame(input logic [23:0] left,
                                                           input logic [23:0] right);
      logic [23:0]     peak, target;
      logic [15:0]     coeff;
      gated_frame_type res;
      peak = magnitude(left);
      if (magnitude(right) > peak) peak = magnitude(right);
      coeff = (peak > env_lvl) ? det_attack_c : det_release_c;
      env_lvl = one_pole(coeff, env_lvl, peak);

      // open, hysteresis band reload, hold count down, close
      if (env_lvl >= open_lvl) begin
         gate_open = 1'b1;
         hold_left = hold_len;
      end else if (gate_open) begin
         if (env_lvl >= close_lvl) hold_left = hold_len;
         else if (hold_left != '0) hold_left = hold_left - 20'd1;
         else gate_open = 1'b0;
      end

      target = gate_open ? ONE_Q23 : floor_lvl;
      coeff = gate_open ? gain_attack_c : gain_release_c;
      gain_lvl = one_pole(coeff, gain_lvl, target);

      res.gated_left = scale_by_gain(left, gain_lvl);
      res.gated_right = scale_by_gain(right, gain_lvl);
      res.gate_open = gate_open;
      res.gain_high = (gain_lvl > HALF_Q23);
      return res;
   endfunction

   // idle length shared by both sides: mostly none, a few long
   function automatic int idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      else if (pick < 88) return $urandom_range(1, 3);
      else if (pick < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // signed sample with magnitude in [lo, hi], clipped to the positive limit
   function automatic logic [23:0] make_sample(input int unsigned lo, input int unsigned hi);
      int unsigned mag;
      int          val;
      mag = ($urandom_range(0, 15) == 0) ? ((hi > lo) ? hi : lo) : $urandom_range(hi, lo);
      if ($urandom_range(0, 1) == 1) val = -int'(mag);
      else val = (mag > 8388607) ? 8388607 : int'(mag);
      return val[23:0];
   endfunction

   // offer one frame, wait for the beat, queue its expected result
   task automatic send_frame(input logic [23:0] left, input logic [23:0] right,
                             input logic has_fixed, input gated_frame_type fixed_result);
      int              gap;
      gated_frame_type predicted;
      gap = gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      do @(posedge clock); while (!req_tready);
      predicted = compute_gated_frame(left, right);
      gated_expect_q.push_back(has_fixed ? fixed_result : predicted);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_DET_ATTACK:   det_attack_c = val[15:0];
         REG_DET_RELEASE:  det_release_c = val[15:0];
         REG_GAIN_ATTACK:  gain_attack_c = val[15:0];
         REG_GAIN_RELEASE: gain_release_c = val[15:0];
         REG_HOLD_SAMPLES: hold_len = val[19:0];
         REG_OPEN_THRESH:  open_lvl = val;
         REG_CLOSE_THRESH: close_lvl = val;
         REG_FLOOR_GAIN:   floor_lvl = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input int unsigned da, input int unsigned dr,
                                input int unsigned ga, input int unsigned gr,
                                input int unsigned hold, input int unsigned open_at,
                                input int unsigned close_at, input int unsigned floor_at);
      csr_write(REG_DET_ATTACK, 24'(da));
      csr_write(REG_DET_RELEASE, 24'(dr));
      csr_write(REG_GAIN_ATTACK, 24'(ga));
      csr_write(REG_GAIN_RELEASE, 24'(gr));
      csr_write(REG_HOLD_SAMPLES, 24'(hold));
      csr_write(REG_OPEN_THRESH, 24'(open_at));
      csr_write(REG_CLOSE_THRESH, 24'(close_at));
      csr_write(REG_FLOOR_GAIN, 24'(floor_at));
      csr_we <= 1'b0;
   endtask

   // bursts of loud, in-band and quiet frames so the gate walks through
   // open, hold and close; some bursts are plain noise
   task automatic run_bursts(input int count);
      int          sent, run_len, kind, j;
      int unsigned lo, hi, quiet_max;
      logic        noise;
      logic [23:0] l, r;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         quiet_max = (hold_len + 6 > 40) ? 40 : hold_len + 6;
         noise = 1'b0;
         if (kind < 2) begin
            noise = 1'b1;
            lo = 0;
            hi = 0;
            run_len = $urandom_range(1, 8);
         end else if (kind < 5) begin
            lo = (open_lvl > 24'd8388608) ? 8388608 : open_lvl;
            hi = 8388608;
            run_len = $urandom_range(1, 20);
         end else if (kind < 7) begin
            lo = (close_lvl > 24'd8388608) ? 8388608 : close_lvl;
            hi = (open_lvl > 24'd8388608) ? 8388608 : open_lvl;
            run_len = $urandom_range(1, 10);
         end else begin
            lo = 0;
            hi = close_lvl / 2;
            run_len = $urandom_range(1, quiet_max);
         end
         for (j = 0; j < run_len && sent < count; j++) begin
            if (noise) begin
               l = 24'($urandom);
               r = 24'($urandom);
            end else begin
               l = make_sample(lo, hi);
               r = ($urandom_range(0, 1) == 1) ? make_sample(lo, hi) : make_sample(0, hi);
            end
            send_frame(l, r, 1'b0, GATED_ZERO);
            sent++;
         end
      end
   endtask

   // stop offering, wait for every result, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (gated_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [23:0] want,
                                  input logic [23:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_off_req != hold_off_seen) begin
         hold_off_seen = hold_off_req;
         stall_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!gaps_on) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_draw = idle_length();
         rsp_tready <= (rsp_draw == 0);
         if (rsp_draw > 0) stall_left = rsp_draw - 1;
      end
   end

   // result beat check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      gated_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gated_expect_q.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with nothing outstanding, expected none actual %h %h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = gated_expect_q.pop_front();
            if (rsp_tdata[23:0] !== want.gated_left)
               report_mismatch("gated_left", want.gated_left, rsp_tdata[23:0]);
            if (rsp_tdata[47:24] !== want.gated_right)
               report_mismatch("gated_right", want.gated_right, rsp_tdata[47:24]);
            if (rsp_tuser[0] !== want.gate_open)
               report_mismatch("gate_is_open", 24'(want.gate_open), 24'(rsp_tuser[0]));
            if (rsp_tuser[1] !== want.gain_high)
               report_mismatch("gain_above_half", 24'(want.gain_high), 24'(rsp_tuser[1]));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, gated_expect_q.size());
         $display("FAIL noise_gate_hysteresis_hold_unit");
         $finish;
      end
   end

   initial begin : stimulus
      int          phase, k;
      int unsigned open_pick;

      // register defaults and cleared state, as after reset
      det_attack_c = 16'd65000;
      det_release_c = 16'd65500;
      gain_attack_c = 16'd65000;
      gain_release_c = 16'd65500;
      hold_len = 20'd4800;
      open_lvl = 24'd83886;
      close_lvl = 24'd41943;
      floor_lvl = 24'd0;
      env_lvl = '0;
      gain_lvl = floor_lvl;
      hold_left = '0;
      gate_open = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset settings
      for (k = 0; k < 22; k++)
         send_frame(DIRECTED_ROWS[k].left, DIRECTED_ROWS[k].right,
                    DIRECTED_ROWS[k].has_fixed, DIRECTED_ROWS[k].fixed_result);
      drain();

      // random phases, each under its own register settings
      for (phase = 1; phase <= 7; phase++) begin
         gaps_on <= (phase != 2 && phase != 5);
         case (phase)
            // low extremes: instant smoothing, gate always open
            2: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
            // high extremes: slowest smoothing, longest hold
            3: load_settings(65535, 65535, 65535, 65535, 1048575, 8388608, 8388608,
                             8388608);
            // floor above unity with the gate held shut: products saturate
            4: load_settings(65535, 65535, $urandom_range(0, 65535), 0, 0, 8388608,
                             8388608, 24'hFFFFFF);
            5, 6: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 12), $urandom_range(0, 8388608),
                                $urandom_range(0, 8388608), $urandom_range(0, 8388608));
            default: begin
               open_pick = $urandom_range(400000, 4000000);
               load_settings($urandom_range(0, 40000), $urandom_range(30000, 64000),
                             $urandom_range(0, 50000), $urandom_range(0, 62000),
                             $urandom_range(0, 6), open_pick,
                             $urandom_range(open_pick / 4, open_pick),
                             $urandom_range(0, 8388608));
            end
         endcase
         if (phase == 7) begin
            // long receiver hold-off while frames keep coming
            run_bursts(30);
            hold_off_req <= hold_off_req + 1;
            run_bursts(PHASE_FRAMES - 30);
         end else begin
            run_bursts(PHASE_FRAMES);
         end
         drain();
      end

      if (fail_count == 0) $display("PASS noise_gate_hysteresis_hold_unit");
      else $display("FAIL noise_gate_hysteresis_hold_unit");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ngh_pkg.sv
rtl/core/ngh_mac.sv
rtl/core/noise_gate_hysteresis_hold_unit.sv
tb/noise_gate_hysteresis_hold_unit_tb.sv
